### design/sorted_key_weighted_pick_unit_macros.svh
// Assertion macros for the sorted key weighted pick unit.
// Included by the files that check their own logic; no other dependencies.
`ifndef SORTED_KEY_WEIGHTED_PICK_UNIT_MACROS_SVH
`define SORTED_KEY_WEIGHTED_PICK_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge out of reset.
`define SKWP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("skwp check failed");
// Condition that must follow in the same cycle from a trigger.
`define SKWP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("skwp check failed");
`else
`define SKWP_ASSERT(lbl, clk, rstn, prop)
`define SKWP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

### design/skwp_pkg.sv
// Shared types and constants of the sorted key weighted pick unit.
// No dependencies; used by the interfaces and by the control, datapath and top modules.
package skwp_pkg;

  localparam int unsigned MAX_KEYS_DEF    = 1024;
  localparam int unsigned MAX_ENTRIES_DEF = 4096;
  localparam int unsigned MAX_PER_KEY_DEF = 255;

  localparam int unsigned KeyW = 64;
  localparam int unsigned ValW = 15;
  localparam int unsigned WtW  = 16;
  localparam int unsigned RndW = 31;
  localparam int unsigned OpW  = 2;
  localparam int unsigned StW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_APPEND_KEY   = 2'd0,
    OP_APPEND_ENTRY = 2'd1,
    OP_LOOKUP       = 2'd2,
    OP_CLEAR        = 2'd3
  } opcode_e;

  typedef enum logic [StW-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_CHOSEN   = 3'd2,
    ST_NONE     = 3'd3,
    ST_NOKEY    = 3'd4
  } status_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic addr_bound;
    logic exp_step;
    logic bin_init;
    logic bin_lower;
    logic bin_upper;
    logic info_cap;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic pick_init;
    logic pick_step;
    logic res_none;
    logic res_chosen;
    logic out_load;
    logic out_from_load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_lookup;
    logic lookup_ok;
    logic exp_more;
    logic key_lt;
    logic bin_open;
    logic bin_hit;
    logic bin_below;
    logic cnt_zero;
    logic i_last;
    logic sum_zero;
    logic div_last;
    logic pick_hit;
    logic slot_free;
  } sts_t;

endpackage

### design/skwp_chan_if.sv
// Channel interfaces of the sorted key weighted pick unit: request, result, config.
// Depends on skwp_pkg for field widths.
interface skwp_in_if;
  logic                        valid;
  logic                        ready;
  logic [skwp_pkg::OpW-1:0]    opcode;
  logic [skwp_pkg::KeyW-1:0]   key_value;
  logic [skwp_pkg::ValW-1:0]   entry_value;
  logic [skwp_pkg::WtW-1:0]    entry_weight;
  logic [skwp_pkg::RndW-1:0]   random_value;
  modport source (output valid, opcode, key_value, entry_value, entry_weight, random_value,
                  input ready);
  modport sink (input valid, opcode, key_value, entry_value, entry_weight, random_value,
                output ready);
endinterface

interface skwp_out_if;
  logic                        valid;
  logic                        ready;
  logic [skwp_pkg::StW-1:0]    status;
  logic [skwp_pkg::ValW-1:0]   chosen_value;
  logic [skwp_pkg::WtW-1:0]    chosen_weight;
  modport source (output valid, status, chosen_value, chosen_weight, input ready);
  modport sink (input valid, status, chosen_value, chosen_weight, output ready);
endinterface

interface skwp_cfg_if;
  logic valid;
  logic ready;
  logic book_enable;
  modport source (output valid, book_enable, input ready);
  modport sink (input valid, book_enable, output ready);
endinterface

### design/skwp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/skwp_ctrl.sv
// Sequencer of the sorted key weighted pick unit: load, search, sum, divide, pick.
// Depends on skwp_pkg for the command and status structs.
module skwp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  skwp_pkg::sts_t sts_i,
  output skwp_pkg::cmd_t cmd_o
);
  import skwp_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_EXP_RD   = 16'h0002,
    S_EXP_CHK  = 16'h0004,
    S_BIN_RD   = 16'h0008,
    S_BIN_CHK  = 16'h0010,
    S_INFO_RD  = 16'h0020,
    S_INFO_CHK = 16'h0040,
    S_SUM_RD   = 16'h0080,
    S_SUM_CHK  = 16'h0100,
    S_SUM_END  = 16'h0200,
    S_DIV      = 16'h0400,
    S_PICK_SET = 16'h0800,
    S_PICK_RD  = 16'h1000,
    S_PICK_CHK = 16'h2000,
    S_FAIL     = 16'h4000,
    S_OUT      = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.slot_free;
        if (in_valid_i && sts_i.slot_free) begin
          if (sts_i.is_lookup) begin
            cmd_o.capture = 1'b1;
            state_d = sts_i.lookup_ok ? S_EXP_RD : S_FAIL;
          end else begin
            // loads finish in the accept cycle
            cmd_o.do_load       = 1'b1;
            cmd_o.out_load      = 1'b1;
            cmd_o.out_from_load = 1'b1;
          end
        end
      end
      S_EXP_RD: begin
        cmd_o.addr_bound = 1'b1;
        if (sts_i.exp_more) begin
          state_d = S_EXP_CHK;
        end else begin
          cmd_o.bin_init = 1'b1;
          state_d = S_BIN_RD;
        end
      end
      S_EXP_CHK: begin
        if (sts_i.key_lt) begin
          cmd_o.exp_step = 1'b1;
          state_d = S_EXP_RD;
        end else begin
          cmd_o.bin_init = 1'b1;
          state_d = S_BIN_RD;
        end
      end
      S_BIN_RD: begin
        state_d = sts_i.bin_open ? S_BIN_CHK : S_FAIL;
      end
      S_BIN_CHK: begin
        if (sts_i.bin_hit) begin
          state_d = S_INFO_RD;
        end else begin
          cmd_o.bin_upper = sts_i.bin_below;
          cmd_o.bin_lower = !sts_i.bin_below;
          state_d = S_BIN_RD;
        end
      end
      S_INFO_RD: begin
        state_d = S_INFO_CHK;
      end
      S_INFO_CHK: begin
        cmd_o.info_cap = 1'b1;
        state_d = sts_i.cnt_zero ? S_FAIL : S_SUM_RD;
      end
      S_SUM_RD: begin
        state_d = S_SUM_CHK;
      end
      S_SUM_CHK: begin
        cmd_o.sum_step = 1'b1;
        state_d = sts_i.i_last ? S_SUM_END : S_SUM_RD;
      end
      S_SUM_END: begin
        if (sts_i.sum_zero) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_PICK_SET;
        end
      end
      S_PICK_SET: begin
        cmd_o.pick_init = 1'b1;
        state_d = S_PICK_RD;
      end
      S_PICK_RD: begin
        state_d = S_PICK_CHK;
      end
      S_PICK_CHK: begin
        cmd_o.pick_step = 1'b1;
        if (sts_i.pick_hit) begin
          cmd_o.res_chosen = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_PICK_RD;
        end
      end
      S_FAIL: begin
        cmd_o.res_none = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (sts_i.slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

### design/skwp_dpath.sv
// Datapath of the sorted key weighted pick unit: stores, search bounds, sums, divider.
// Depends on skwp_pkg, skwp_ram and the assertion macro header.
`include "sorted_key_weighted_pick_unit_macros.svh"
module skwp_dpath #(
  parameter int unsigned MaxKeys    = skwp_pkg::MAX_KEYS_DEF,
  parameter int unsigned MaxEntries = skwp_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MaxPerKey  = skwp_pkg::MAX_PER_KEY_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_en_i,
  input  logic [skwp_pkg::OpW-1:0]  opcode_i,
  input  logic [skwp_pkg::KeyW-1:0] key_i,
  input  logic [skwp_pkg::ValW-1:0] value_i,
  input  logic [skwp_pkg::WtW-1:0]  weight_i,
  input  logic [skwp_pkg::RndW-1:0] rnd_i,
  input  skwp_pkg::cmd_t            cmd_i,
  output skwp_pkg::sts_t            sts_o,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [skwp_pkg::StW-1:0]  out_status_o,
  output logic [skwp_pkg::ValW-1:0] out_value_o,
  output logic [skwp_pkg::WtW-1:0]  out_weight_o
);
  import skwp_pkg::*;

  localparam int unsigned KAW = $clog2(MaxKeys);
  localparam int unsigned KCW = $clog2(MaxKeys + 1);
  localparam int unsigned BW  = KCW + 1;
  localparam int unsigned EAW = $clog2(MaxEntries);
  localparam int unsigned ECW = $clog2(MaxEntries + 1);
  localparam int unsigned CW  = $clog2(MaxPerKey + 1);
  localparam int unsigned IW  = EAW + CW;
  localparam int unsigned SW  = WtW + CW;
  localparam int unsigned DCW = $clog2(RndW);
  localparam int unsigned EW  = ValW + WtW;

  // control state
  logic           en_q;
  logic [KCW-1:0] n_q;
  logic [ECW-1:0] ec_q;
  logic [CW-1:0]  last_cnt_q;
  logic           ov_q;
  // payload
  logic [EAW-1:0]  last_base_q;
  logic [KeyW-1:0] key_q;
  logic [RndW-1:0] dvd_q;
  logic [BW-1:0]   bound_q, lo_q, hip_q;
  logic [EAW-1:0]  base_q;
  logic [CW-1:0]   cnt_q, i_q;
  logic [SW-1:0]   sum_q, rem_q, r_q, run_q;
  logic [DCW-1:0]  dcnt_q;
  status_e         res_st_q, o_st_q;
  logic [ValW-1:0] res_val_q, o_val_q;
  logic [WtW-1:0]  res_wt_q, o_wt_q;

  // memories
  logic            key_we, ent_we, info_we;
  logic [KAW-1:0]  key_raddr, info_waddr;
  logic [KeyW-1:0] key_rdata;
  logic [IW-1:0]   info_wdata, info_rdata;
  logic [EAW-1:0]  ent_raddr;
  logic [EW-1:0]   ent_rdata;

  logic [KCW-1:0]  n_last;
  logic [BW:0]     mid_sum, bnd_p2;
  logic [BW-1:0]   mid, hip_init;
  logic [IW-1:0]   ent_addr_full;
  logic [WtW-1:0]  ent_wt;
  logic [SW-1:0]   sum_new, run_new, rem_next;
  logic [SW:0]     rem_sh;
  status_e         ld_st;

  assign n_last   = n_q - 1'b1;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hip_q} - 1'b1;
  assign mid      = mid_sum[BW:1];
  assign bnd_p2   = {1'b0, bound_q} + (BW+1)'(2);
  assign hip_init = (bnd_p2 < (BW+1)'(n_q)) ? bnd_p2[BW-1:0] : BW'(n_q);
  assign key_raddr = cmd_i.addr_bound ? bound_q[KAW-1:0] : mid[KAW-1:0];
  assign ent_addr_full = IW'(base_q) + IW'(i_q);
  assign ent_raddr = ent_addr_full[EAW-1:0];
  assign ent_wt    = ent_rdata[ValW +: WtW];
  assign sum_new   = sum_q + SW'(ent_wt);
  assign run_new   = run_q + SW'(ent_wt);
  assign rem_sh    = {rem_q, dvd_q[RndW-1]};
  assign rem_next  = (rem_sh >= {1'b0, sum_q}) ? SW'(rem_sh - {1'b0, sum_q}) : rem_sh[SW-1:0];

  // load decode
  always_comb begin
    ld_st      = ST_ACCEPTED;
    key_we     = 1'b0;
    ent_we     = 1'b0;
    info_we    = 1'b0;
    info_waddr = n_q[KAW-1:0];
    info_wdata = {ec_q[EAW-1:0], {CW{1'b0}}};
    unique case (opcode_i)
      OP_APPEND_KEY: begin
        if (n_q >= KCW'(MaxKeys)) begin
          ld_st = ST_FULL;
        end else begin
          key_we  = cmd_i.do_load;
          info_we = cmd_i.do_load;
        end
      end
      OP_APPEND_ENTRY: begin
        info_waddr = n_last[KAW-1:0];
        info_wdata = {last_base_q, last_cnt_q + 1'b1};
        if (n_q == '0) begin
          ld_st = ST_NOKEY;
        end else if (ec_q >= ECW'(MaxEntries) || last_cnt_q >= CW'(MaxPerKey)) begin
          ld_st = ST_FULL;
        end else begin
          ent_we  = cmd_i.do_load;
          info_we = cmd_i.do_load;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    sts_o.is_lookup = (opcode_i == OP_LOOKUP);
    sts_o.lookup_ok = en_q && (n_q != '0);
    sts_o.exp_more  = (bound_q < BW'(n_q));
    sts_o.key_lt    = (key_rdata < key_q);
    sts_o.bin_open  = (lo_q < hip_q);
    sts_o.bin_hit   = (key_rdata == key_q);
    sts_o.bin_below = (key_q < key_rdata);
    sts_o.cnt_zero  = (info_rdata[CW-1:0] == '0);
    sts_o.i_last    = (i_q == cnt_q - 1'b1);
    sts_o.sum_zero  = (sum_q == '0);
    sts_o.div_last  = (dcnt_q == DCW'(RndW - 1));
    sts_o.pick_hit  = (run_new >= r_q);
    sts_o.slot_free = !ov_q || out_ready_i;
  end

  skwp_ram #(.Width(KeyW), .Depth(MaxKeys)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(n_q[KAW-1:0]), .wdata_i(key_i),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  skwp_ram #(.Width(IW), .Depth(MaxKeys)) u_info_ram (
    .clk_i, .we_i(info_we), .waddr_i(info_waddr), .wdata_i(info_wdata),
    .raddr_i(mid[KAW-1:0]), .rdata_o(info_rdata)
  );

  skwp_ram #(.Width(EW), .Depth(MaxEntries)) u_ent_ram (
    .clk_i, .we_i(ent_we), .waddr_i(ec_q[EAW-1:0]), .wdata_i({weight_i, value_i}),
    .raddr_i(ent_raddr), .rdata_o(ent_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      n_q        <= '0;
      ec_q       <= '0;
      last_cnt_q <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_en_i;
      end
      if (cmd_i.do_load) begin
        if (opcode_i == OP_CLEAR) begin
          n_q  <= '0;
          ec_q <= '0;
        end else if (key_we) begin
          n_q        <= n_q + 1'b1;
          last_cnt_q <= '0;
        end else if (ent_we) begin
          ec_q       <= ec_q + 1'b1;
          last_cnt_q <= last_cnt_q + 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      last_base_q <= ec_q[EAW-1:0];
    end
    if (cmd_i.capture) begin
      key_q   <= key_i;
      dvd_q   <= rnd_i;
      bound_q <= BW'(1);
    end
    if (cmd_i.exp_step) begin
      bound_q <= {bound_q[BW-2:0], 1'b0};
    end
    if (cmd_i.bin_init) begin
      lo_q  <= bound_q >> 1;
      hip_q <= hip_init;
    end
    if (cmd_i.bin_lower) begin
      lo_q <= mid + 1'b1;
    end
    if (cmd_i.bin_upper) begin
      hip_q <= mid;
    end
    if (cmd_i.info_cap) begin
      base_q <= info_rdata[IW-1:CW];
      cnt_q  <= info_rdata[CW-1:0];
      i_q    <= '0;
      sum_q  <= '0;
    end
    if (cmd_i.sum_step) begin
      sum_q <= sum_new;
      i_q   <= i_q + 1'b1;
    end
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      // restoring division, one dividend bit per cycle
      rem_q  <= rem_next;
      dvd_q  <= {dvd_q[RndW-2:0], 1'b0};
      dcnt_q <= dcnt_q + 1'b1;
    end
    if (cmd_i.pick_init) begin
      r_q   <= rem_q + 1'b1;
      run_q <= '0;
      i_q   <= '0;
    end
    if (cmd_i.pick_step) begin
      run_q <= run_new;
      i_q   <= i_q + 1'b1;
    end
    if (cmd_i.res_none) begin
      res_st_q  <= ST_NONE;
      res_val_q <= '0;
      res_wt_q  <= '0;
    end
    if (cmd_i.res_chosen) begin
      res_st_q  <= ST_CHOSEN;
      res_val_q <= ent_rdata[ValW-1:0];
      res_wt_q  <= ent_wt;
    end
    if (cmd_i.out_load) begin
      o_st_q  <= cmd_i.out_from_load ? ld_st : res_st_q;
      o_val_q <= cmd_i.out_from_load ? '0 : res_val_q;
      o_wt_q  <= cmd_i.out_from_load ? '0 : res_wt_q;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_status_o = o_st_q;
  assign out_value_o  = o_val_q;
  assign out_weight_o = o_wt_q;

  `SKWP_ASSERT(a_key_cnt_max, clk_i, rst_ni, n_q <= KCW'(MaxKeys))
  `SKWP_ASSERT(a_ent_cnt_max, clk_i, rst_ni, ec_q <= ECW'(MaxEntries))
  `SKWP_ASSERT_IMP(a_pick_nonzero, clk_i, rst_ni, cmd_i.pick_step && sts_o.pick_hit, ent_wt != '0)
  `SKWP_ASSERT_IMP(a_bin_mid_in_range, clk_i, rst_ni, cmd_i.bin_lower || cmd_i.bin_upper, mid < BW'(n_q))
endmodule

### design/sorted_key_weighted_pick_unit.sv
// Sorted key weighted pick unit, top level.
// Request channel in_i carries one word per operation: append key, append entry,
// lookup or clear table. Result channel out_o returns exactly one word per request
// (status, chosen value, chosen weight). cfg_i writes book_enable; it is always ready
// and must only be written while the unit is idle.
// Loads and clears write their result to the output register in the accept cycle.
// A lookup runs a sequencer over the key, info and entry RAMs: an exponential search and
// a binary search for the key, a pass over its entries to sum the weights, the
// bit-serial modulo unit, and a scan of the entries for the pick. Each search, sum and
// pick step reads a RAM and checks its registered read data. One item is in work at a time.
// The output register holds one result; while it is full and out_o.ready is low, no
// new request is accepted and a finished lookup waits.
// Reset clears the key and entry counts, book_enable and the output valid; the stores
// need no clearing since every read is bounded by the counts.
// Depends on skwp_pkg, skwp_chan_if, skwp_ctrl, skwp_dpath and skwp_ram.
module sorted_key_weighted_pick_unit #(
  parameter int unsigned MaxKeys    = skwp_pkg::MAX_KEYS_DEF,
  parameter int unsigned MaxEntries = skwp_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned MaxPerKey  = skwp_pkg::MAX_PER_KEY_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  skwp_in_if.sink     in_i,
  skwp_out_if.source  out_o,
  skwp_cfg_if.sink    cfg_i
);
  import skwp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  skwp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  skwp_dpath #(
    .MaxKeys(MaxKeys), .MaxEntries(MaxEntries), .MaxPerKey(MaxPerKey)
  ) u_dpath (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_i.valid), .cfg_en_i(cfg_i.book_enable),
    .opcode_i(in_i.opcode), .key_i(in_i.key_value), .value_i(in_i.entry_value),
    .weight_i(in_i.entry_weight), .rnd_i(in_i.random_value),
    .cmd_i(cmd), .sts_o(sts),
    .out_ready_i(out_o.ready), .out_valid_o(out_o.valid),
    .out_status_o(out_o.status), .out_value_o(out_o.chosen_value),
    .out_weight_o(out_o.chosen_weight)
  );
endmodule
